@@ rtl/pse_pkg.sv @@
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, character codes and helpers of the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_SLASH  = 8'h2F;
	localparam logic [7:0] CHAR_CARET  = 8'h5E;
	localparam logic [7:0] CHAR_LPAREN = 8'h28;
	localparam logic [7:0] CHAR_RPAREN = 8'h29;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_DIV0  = 3'd2,
		ST_FULL  = 3'd3,
		ST_ZNEG  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		TK_OPERAND,
		TK_ARITH,
		TK_PAREN
	} tok_kind_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV,
		ALU_POW
	} alu_op_t;

	typedef struct packed {
		logic load;
		logic push_operand;
		logic pop_b;
		logic pop_a;
		logic grab_a;
		logic alu_start;
		logic push_result;
		logic read_top;
		logic load_out;
	} pse_cmd_t;

	typedef struct packed {
		tok_kind_t kind;
		logic      alu_done;
	} pse_sts_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic    done;
		status_t fault;
	} alu_rsp_t;

	function automatic tok_kind_t tok_kind(input logic [7:0] tok);
		tok_kind_t k;
		case (tok)
			CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH, CHAR_CARET: k = TK_ARITH;
			CHAR_LPAREN, CHAR_RPAREN: k = TK_PAREN;
			default: k = TK_OPERAND;
		endcase
		return k;
	endfunction

	function automatic alu_op_t tok_alu_op(input logic [7:0] tok);
		alu_op_t op;
		case (tok)
			CHAR_MINUS: op = ALU_SUB;
			CHAR_STAR:  op = ALU_MUL;
			CHAR_SLASH: op = ALU_DIV;
			CHAR_CARET: op = ALU_POW;
			default:    op = ALU_ADD;
		endcase
		return op;
	endfunction

endpackage

@@ rtl/pse_in_if.sv @@
// ----------------------------------------------------------------------------
// pse_in_if
// Input channel: one expression character per word.
// ----------------------------------------------------------------------------
interface pse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] token;
	logic       last_token;

	modport source (output valid, output token, output last_token, input ready);
	modport sink   (input valid, input token, input last_token, output ready);
endinterface

@@ rtl/pse_out_if.sv @@
// ----------------------------------------------------------------------------
// pse_out_if
// Result channel: stack top, depth and status after each character.
// ----------------------------------------------------------------------------
interface pse_out_if #(
	parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF,
	parameter int DEPTH_WIDTH = $clog2(pse_pkg::STACK_DEPTH_DEF + 1)
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] top_value;
	logic [DEPTH_WIDTH-1:0]        stack_depth;
	pse_pkg::status_t              status;
	logic                          final_result;

	modport source (output valid, output top_value, output stack_depth, output status,
		output final_result, input ready);
	modport sink   (input valid, input top_value, input stack_depth, input status,
		input final_result, output ready);
endinterface

@@ rtl/pse_alu.sv @@
// ----------------------------------------------------------------------------
// pse_alu
// Multi-cycle arithmetic unit: add, subtract, digit-serial multiply,
// restoring divide and square-and-multiply power.
// ----------------------------------------------------------------------------
module pse_alu #(
	parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pse_pkg::alu_req_t      req,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [VALUE_WIDTH-1:0] b,
	output pse_pkg::alu_rsp_t      rsp,
	output logic [VALUE_WIDTH-1:0] result
);
	import pse_pkg::*;

	localparam int W        = VALUE_WIDTH;
	localparam int MulDigit = 8;
	localparam int CntW     = $clog2(W + 1);

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_POW,
		A_DIV,
		A_DIVFIN,
		A_DONE
	} alu_state_t;

	typedef enum logic [1:0] {
		DST_RES,
		DST_ACC,
		DST_SQ
	} mul_dst_t;

	alu_state_t          state_q;
	mul_dst_t            dst_q;
	status_t             fault_q;
	logic [W-1:0]        res_q;
	logic [W-1:0]        mcand_q;
	logic [W-1:0]        mpl_q;
	logic [W-1:0]        prod_q;
	logic [W-1:0]        acc_q;
	logic [W-1:0]        sq_q;
	logic [W-1:0]        exp_q;
	logic                acc_done_q;
	logic [W-1:0]        quo_q;
	logic [W-1:0]        dvs_q;
	logic [W-1:0]        rem_q;
	logic                neg_q;
	logic [CntW-1:0]     cnt_q;
	logic [W+MulDigit-1:0] mul_part;
	logic [W:0]          rem_shift;
	logic [W:0]          rem_diff;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	assign mul_part  = mcand_q * mpl_q[MulDigit-1:0];
	assign rem_shift = {rem_q, quo_q[W-1]};
	assign rem_diff  = rem_shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= A_IDLE;
			dst_q      <= DST_RES;
			fault_q    <= ST_OK;
			res_q      <= '0;
			mcand_q    <= '0;
			mpl_q      <= '0;
			prod_q     <= '0;
			acc_q      <= '0;
			sq_q       <= '0;
			exp_q      <= '0;
			acc_done_q <= 1'b0;
			quo_q      <= '0;
			dvs_q      <= '0;
			rem_q      <= '0;
			neg_q      <= 1'b0;
			cnt_q      <= '0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						fault_q <= ST_OK;
						unique case (req.op)
							ALU_ADD: begin
								res_q   <= a + b;
								state_q <= A_DONE;
							end
							ALU_SUB: begin
								res_q   <= a - b;
								state_q <= A_DONE;
							end
							ALU_MUL: begin
								mcand_q <= a;
								mpl_q   <= b;
								prod_q  <= '0;
								dst_q   <= DST_RES;
								state_q <= A_MUL;
							end
							ALU_DIV: begin
								if (b == '0) begin
									res_q   <= '0;
									fault_q <= ST_DIV0;
									state_q <= A_DONE;
								end else begin
									quo_q   <= mag(a);
									dvs_q   <= mag(b);
									rem_q   <= '0;
									neg_q   <= a[W-1] ^ b[W-1];
									cnt_q   <= CntW'(W);
									state_q <= A_DIV;
								end
							end
							ALU_POW: begin
								if (b[W-1]) begin
									state_q <= A_DONE;
									if (a == W'(1)) begin
										res_q <= W'(1);
									end else if (a == '1) begin
										res_q <= b[0] ? '1 : W'(1);
									end else if (a == '0) begin
										res_q   <= '0;
										fault_q <= ST_ZNEG;
									end else begin
										res_q <= '0;
									end
								end else begin
									acc_q      <= W'(1);
									sq_q       <= a;
									exp_q      <= b;
									acc_done_q <= 1'b0;
									state_q    <= A_POW;
								end
							end
							default: begin
								res_q   <= '0;
								state_q <= A_DONE;
							end
						endcase
					end
				end
				A_POW: begin
					if (exp_q == '0) begin
						res_q   <= acc_q;
						state_q <= A_DONE;
					end else if (exp_q[0] && !acc_done_q) begin
						mcand_q    <= acc_q;
						mpl_q      <= sq_q;
						prod_q     <= '0;
						dst_q      <= DST_ACC;
						acc_done_q <= 1'b1;
						state_q    <= A_MUL;
					end else begin
						mcand_q <= sq_q;
						mpl_q   <= sq_q;
						prod_q  <= '0;
						dst_q   <= DST_SQ;
						state_q <= A_MUL;
					end
				end
				A_MUL: begin
					if (mpl_q == '0) begin
						unique case (dst_q)
							DST_RES: begin
								res_q   <= prod_q;
								state_q <= A_DONE;
							end
							DST_ACC: begin
								acc_q   <= prod_q;
								state_q <= A_POW;
							end
							DST_SQ: begin
								sq_q       <= prod_q;
								exp_q      <= exp_q >> 1;
								acc_done_q <= 1'b0;
								state_q    <= A_POW;
							end
							default: state_q <= A_DONE;
						endcase
					end else begin
						prod_q  <= prod_q + mul_part[W-1:0];
						mcand_q <= mcand_q << MulDigit;
						mpl_q   <= mpl_q >> MulDigit;
					end
				end
				A_DIV: begin
					if (!rem_diff[W]) begin
						rem_q <= rem_diff[W-1:0];
					end else begin
						rem_q <= rem_shift[W-1:0];
					end
					quo_q <= {quo_q[W-2:0], ~rem_diff[W]};
					cnt_q <= cnt_q - CntW'(1);
					if (cnt_q == CntW'(1)) begin
						state_q <= A_DIVFIN;
					end
				end
				A_DIVFIN: begin
					res_q   <= neg_q ? (~quo_q + W'(1)) : quo_q;
					state_q <= A_DONE;
				end
				A_DONE: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign rsp.done  = (state_q == A_DONE);
	assign rsp.fault = fault_q;
	assign result    = res_q;

endmodule

@@ rtl/pse_dp.sv @@
// ----------------------------------------------------------------------------
// pse_dp
// Datapath: value stack memory, stack pointer, operand registers,
// arithmetic unit and result register.
// ----------------------------------------------------------------------------
module pse_dp #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF,
	parameter int PTR_WIDTH   = $clog2(STACK_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pse_pkg::pse_cmd_t      cmd,
	output pse_pkg::pse_sts_t      sts,
	input  logic [7:0]             token,
	input  logic                   last_token,
	output logic [VALUE_WIDTH-1:0] top_value,
	output logic [PTR_WIDTH-1:0]   stack_depth,
	output pse_pkg::status_t       status,
	output logic                   final_result
);
	import pse_pkg::*;

	localparam int W     = VALUE_WIDTH;
	localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [W-1:0]         stack_q [STACK_DEPTH];
	logic [W-1:0]         rdata_q;
	logic [PTR_WIDTH-1:0] sp_q;
	logic [PTR_WIDTH-1:0] sp_dec;
	logic                 sp_empty;
	logic                 sp_full;
	logic [7:0]           tok_q;
	logic                 last_q;
	logic                 missing_q;
	logic                 b_mem_q;
	logic                 a_mem_q;
	logic [W-1:0]         opa_q;
	logic [W-1:0]         opb_q;
	status_t              status_q;
	logic [W-1:0]         top_q;
	logic [PTR_WIDTH-1:0] depth_q;
	status_t              stat_out_q;
	logic                 final_q;
	logic                 wr_en;
	logic [W-1:0]         wr_data;
	logic                 rd_en;
	logic [W-1:0]         opd_val;
	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;
	logic [W-1:0]         alu_res;

	assign sp_dec   = sp_q - PTR_WIDTH'(1);
	assign sp_empty = (sp_q == '0);
	assign sp_full  = (sp_q == PTR_WIDTH'(STACK_DEPTH));
	assign opd_val  = W'(tok_q) - W'(CHAR_ZERO);

	assign wr_en   = (cmd.push_operand && !sp_full) || cmd.push_result;
	assign wr_data = cmd.push_result ? alu_res : opd_val;
	assign rd_en   = (cmd.pop_b || cmd.pop_a || cmd.read_top) && !sp_empty;

	assign alu_req.start = cmd.alu_start;
	assign alu_req.op    = tok_alu_op(tok_q);

	pse_alu #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.a     (opa_q),
		.b     (opb_q),
		.rsp   (alu_rsp),
		.result(alu_res)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_q[sp_q[AddrW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= stack_q[sp_dec[AddrW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			if (cmd.push_operand && !sp_full) begin
				sp_q <= sp_q + PTR_WIDTH'(1);
			end else if ((cmd.pop_b || cmd.pop_a) && !sp_empty) begin
				sp_q <= sp_dec;
			end else if (cmd.push_result) begin
				sp_q <= sp_q + PTR_WIDTH'(1);
			end else if (cmd.load_out && last_q) begin
				sp_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tok_q     <= token;
			last_q    <= last_token;
			missing_q <= 1'b0;
			status_q  <= ST_OK;
		end
		if (cmd.push_operand) begin
			status_q <= sp_full ? ST_FULL : ST_OK;
		end
		if (cmd.pop_b) begin
			b_mem_q <= !sp_empty;
			if (sp_empty) begin
				missing_q <= 1'b1;
			end
		end
		if (cmd.pop_a) begin
			opb_q   <= b_mem_q ? rdata_q : '1;
			a_mem_q <= !sp_empty;
			if (sp_empty) begin
				missing_q <= 1'b1;
			end
		end
		if (cmd.grab_a) begin
			opa_q    <= a_mem_q ? rdata_q : '1;
			status_q <= missing_q ? ST_EMPTY : ST_OK;
		end
		if (cmd.push_result && alu_rsp.fault != ST_OK) begin
			status_q <= alu_rsp.fault;
		end
		if (cmd.load_out) begin
			top_q      <= sp_empty ? '1 : rdata_q;
			depth_q    <= sp_q;
			stat_out_q <= status_q;
			final_q    <= last_q;
		end
	end

	assign sts.kind     = tok_kind(tok_q);
	assign sts.alu_done = alu_rsp.done;

	assign top_value    = top_q;
	assign stack_depth  = depth_q;
	assign status       = stat_out_q;
	assign final_result = final_q;

endmodule

@@ rtl/pse_ctrl.sv @@
// ----------------------------------------------------------------------------
// pse_ctrl
// Controller: sequences stack accesses and the arithmetic unit for each
// character, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module pse_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pse_pkg::pse_cmd_t cmd,
	input  pse_pkg::pse_sts_t sts
);
	import pse_pkg::*;

	typedef enum logic [2:0] {
		C_IDLE,
		C_DISPATCH,
		C_POP_A,
		C_GRAB_A,
		C_EXEC,
		C_WAIT,
		C_READ_TOP,
		C_OUT
	} ctrl_state_t;

	ctrl_state_t state_q;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == C_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			C_IDLE:     cmd.load = in_valid;
			C_DISPATCH: begin
				if (sts.kind == TK_OPERAND) begin
					cmd.push_operand = 1'b1;
				end else begin
					cmd.pop_b = 1'b1;
				end
			end
			C_POP_A:    cmd.pop_a = 1'b1;
			C_GRAB_A:   cmd.grab_a = 1'b1;
			C_EXEC:     cmd.alu_start = 1'b1;
			C_WAIT:     cmd.push_result = sts.alu_done;
			C_READ_TOP: cmd.read_top = 1'b1;
			C_OUT:      cmd.load_out = out_free;
			default:    cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == C_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				C_IDLE: begin
					if (in_valid) begin
						state_q <= C_DISPATCH;
					end
				end
				C_DISPATCH: begin
					if (sts.kind == TK_OPERAND) begin
						state_q <= C_READ_TOP;
					end else begin
						state_q <= C_POP_A;
					end
				end
				C_POP_A: state_q <= C_GRAB_A;
				C_GRAB_A: begin
					if (sts.kind == TK_PAREN) begin
						state_q <= C_READ_TOP;
					end else begin
						state_q <= C_EXEC;
					end
				end
				C_EXEC: state_q <= C_WAIT;
				C_WAIT: begin
					if (sts.alu_done) begin
						state_q <= C_READ_TOP;
					end
				end
				C_READ_TOP: state_q <= C_OUT;
				C_OUT: begin
					if (out_free) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/postfix_stack_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Evaluates a postfix expression one character per input word and returns
// one result word per character: the stack top (-1 when empty), the depth,
// a status code and a flag on the final character, after which the stack
// empties. One character is in work at a time; a finished result waits in
// an output register while the next character is taken. A multiply works
// through the 8-bit digits of the right operand up to its highest nonzero
// digit, and a divide by a nonzero value through all VALUE_WIDTH bits.
// Power runs square-and-multiply over the exponent bits, each bit costing
// up to two digit-serial multiplies. The arithmetic unit is shared by all
// operators and retires one digit or bit per cycle.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = pse_pkg::VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pse_in_if.sink    in_ch,
	pse_out_if.source out_ch
);
	import pse_pkg::*;

	localparam int DepthW = $clog2(STACK_DEPTH + 1);

	pse_cmd_t              cmd;
	pse_sts_t              sts;
	logic [VALUE_WIDTH-1:0] top_value;
	logic [DepthW-1:0]     stack_depth;
	status_t               status;
	logic                  final_result;

	pse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pse_dp #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH),
		.PTR_WIDTH  (DepthW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.token       (in_ch.token),
		.last_token  (in_ch.last_token),
		.top_value   (top_value),
		.stack_depth (stack_depth),
		.status      (status),
		.final_result(final_result)
	);

	assign out_ch.top_value    = top_value;
	assign out_ch.stack_depth  = stack_depth;
	assign out_ch.status       = status;
	assign out_ch.final_result = final_result;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input taken while a word is in work");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.stack_depth == '0 |-> out_ch.top_value == '1)
		else $error("empty stack must show -1 on top");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status == ST_FULL |-> out_ch.stack_depth == DepthW'(STACK_DEPTH))
		else $error("full status with stack not full");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.status == ST_DIV0 || out_ch.status == ST_ZNEG)
		|-> out_ch.top_value == '0)
		else $error("arithmetic fault must leave zero on top");
`endif

endmodule
